[rtl/core/srgbfs_pkg.sv]
package srgbfs_pkg;

  localparam int RowsDefault = 16;
  localparam int ColsDefault = 32;

  localparam int LevelW = 10;
  localparam int OperandW = 12;
  localparam int PixelW = 3 * LevelW;
  localparam int PaddrW = 3;

  localparam logic [LevelW-1:0] ResetLevel = 10'd1000;

  localparam logic [2:0] ModeWrite = 3'd0;
  localparam logic [2:0] ModeRead = 3'd1;
  localparam logic [2:0] ModeAdd = 3'd2;
  localparam logic [2:0] ModeSub = 3'd3;
  localparam logic [2:0] ModeFill = 3'd4;

  localparam logic RegMaxLevel = 1'b0;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StExec,
    StFill
  } state_e;

  typedef struct packed {
    logic [2:0]                 mode;
    logic [7:0]                 row;
    logic [7:0]                 col;
    logic signed [OperandW-1:0] in_red;
    logic signed [OperandW-1:0] in_green;
    logic signed [OperandW-1:0] in_blue;
  } pixel_req_t;

  typedef struct packed {
    logic [LevelW-1:0] out_red;
    logic [LevelW-1:0] out_green;
    logic [LevelW-1:0] out_blue;
    logic              location_valid;
    logic              clipped;
  } pixel_rsp_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              clip;
  } clamp_t;

  function automatic clamp_t clamp_level(logic signed [OperandW-1:0] v,
                                         logic [LevelW-1:0] max_level);
    clamp_t res;
    res.clip = 1'b0;
    res.level = v[LevelW-1:0];
    if (v < 0) begin
      res.clip = 1'b1;
      res.level = '0;
    end else if (v > $signed({2'b00, max_level})) begin
      res.clip = 1'b1;
      res.level = max_level;
    end
    return res;
  endfunction

endpackage

[rtl/core/saturating_rgb_frame_store_top.sv]
// Saturating RGB frame store, ROWS x COLS pixels of three 10-bit channels.
// Request channel (in_valid_i/in_ready_o, in_req_i): mode, row, col and a
// signed colour operand. Each request yields exactly one response on the
// response channel (out_valid_o/out_ready_i, out_rsp_o).
// Requests are handled one at a time: a pixel request (write, read, add,
// subtract) has its memory word read synchronously when it is accepted;
// then, in the execute state, it is modified, written back and its response
// is registered. Execute waits while the output register is still full.
// A fill request sweeps the memory one pixel per cycle, then its response
// is registered from the execute state.
// After reset the memory is swept to white (level 1000); in_ready_o stays
// low meanwhile. max_level resets to 1000 and is written through the APB
// port; the user must write it only while idle: the block does not enforce it.
// The response sits in an output register; when the receiver stalls, the
// next request is still accepted and read, then waits until the register
// frees before it writes back.
module saturating_rgb_frame_store_top
  import srgbfs_pkg::*;
#(
  parameter int Rows = RowsDefault,
  parameter int Cols = ColsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pixel_req_t        in_req_i,

  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pixel_rsp_t        out_rsp_o,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int Depth = Rows * Cols;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  state_e state_q, state_d;

  logic [LevelW-1:0] max_level_q;

  pixel_req_t        req_q;
  logic              loc_valid_q;
  logic [AddrW-1:0]  addr_q;
  logic [AddrW-1:0]  fill_idx_q;
  logic              fill_last;

  logic [PixelW-1:0] mem [Depth];
  logic [PixelW-1:0] rdata_q;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [PixelW-1:0] mem_wdata;

  logic              in_fire;
  logic              out_free;
  logic              out_load;
  logic              in_loc_valid;
  logic [16:0]       in_addr_full;
  logic [AddrW-1:0]  in_addr;

  logic              out_valid_q;
  pixel_rsp_t        out_rsp_q;
  pixel_rsp_t        rsp;

  clamp_t op_r, op_g, op_b;
  clamp_t sum_r, sum_g, sum_b;
  logic [LevelW-1:0] st_r, st_g, st_b;
  logic signed [OperandW-1:0] calc_r, calc_g, calc_b;
  logic              op_clip;
  logic              pix_write;

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr[PaddrW-1] == RegMaxLevel) ? {22'd0, max_level_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q <= ResetLevel;
    end else if (psel && penable && pwrite && pready && paddr[PaddrW-1] == RegMaxLevel) begin
      max_level_q <= pwdata[LevelW-1:0];
    end
  end

  // request decode
  assign in_fire = in_valid_i && in_ready_o;
  assign in_loc_valid = ({1'b0, in_req_i.row} < 9'(Rows)) && ({1'b0, in_req_i.col} < 9'(Cols));
  assign in_addr_full = 17'(in_req_i.row) * 17'(Cols) + 17'(in_req_i.col);
  assign in_addr = in_loc_valid ? in_addr_full[AddrW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_req_i;
      loc_valid_q <= in_loc_valid;
      addr_q <= in_addr;
    end
  end

  // pixel memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rdata_q <= mem[in_addr];
    end
  end

  // datapath
  assign op_r = clamp_level(req_q.in_red, max_level_q);
  assign op_g = clamp_level(req_q.in_green, max_level_q);
  assign op_b = clamp_level(req_q.in_blue, max_level_q);
  assign op_clip = op_r.clip | op_g.clip | op_b.clip;

  assign st_r = rdata_q[3*LevelW-1:2*LevelW];
  assign st_g = rdata_q[2*LevelW-1:LevelW];
  assign st_b = rdata_q[LevelW-1:0];

  always_comb begin
    if (req_q.mode == ModeSub) begin
      calc_r = $signed({2'b00, st_r}) - $signed({2'b00, op_r.level});
      calc_g = $signed({2'b00, st_g}) - $signed({2'b00, op_g.level});
      calc_b = $signed({2'b00, st_b}) - $signed({2'b00, op_b.level});
    end else begin
      calc_r = $signed({2'b00, st_r}) + $signed({2'b00, op_r.level});
      calc_g = $signed({2'b00, st_g}) + $signed({2'b00, op_g.level});
      calc_b = $signed({2'b00, st_b}) + $signed({2'b00, op_b.level});
    end
  end

  assign sum_r = clamp_level(calc_r, max_level_q);
  assign sum_g = clamp_level(calc_g, max_level_q);
  assign sum_b = clamp_level(calc_b, max_level_q);

  always_comb begin
    rsp = '0;
    rsp.location_valid = loc_valid_q;
    pix_write = 1'b0;
    if (req_q.mode == ModeFill) begin
      rsp.out_red = op_r.level;
      rsp.out_green = op_g.level;
      rsp.out_blue = op_b.level;
      rsp.clipped = op_clip;
    end else if (loc_valid_q) begin
      case (req_q.mode) inside
        ModeWrite: begin
          rsp.out_red = op_r.level;
          rsp.out_green = op_g.level;
          rsp.out_blue = op_b.level;
          rsp.clipped = op_clip;
          pix_write = 1'b1;
        end
        ModeAdd, ModeSub: begin
          rsp.out_red = sum_r.level;
          rsp.out_green = sum_g.level;
          rsp.out_blue = sum_b.level;
          rsp.clipped = op_clip | sum_r.clip | sum_g.clip | sum_b.clip;
          pix_write = 1'b1;
        end
        default: begin
          rsp.out_red = st_r;
          rsp.out_green = st_g;
          rsp.out_blue = st_b;
        end
      endcase
    end
  end

  // control
  assign out_free = !out_valid_q || out_ready_i;
  assign fill_last = (fill_idx_q == AddrW'(Depth - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: begin
        if (fill_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_fire) begin
          state_d = (in_req_i.mode == ModeFill) ? StFill : StExec;
        end
      end
      StFill: begin
        if (fill_last) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    mem_we = 1'b0;
    mem_waddr = fill_idx_q;
    mem_wdata = {op_r.level, op_g.level, op_b.level};
    out_load = 1'b0;
    unique case (state_q)
      StClear: begin
        mem_we = 1'b1;
        mem_wdata = {ResetLevel, ResetLevel, ResetLevel};
      end
      StIdle: begin
        in_ready_o = 1'b1;
      end
      StFill: begin
        mem_we = 1'b1;
      end
      StExec: begin
        out_load = out_free;
        mem_we = out_free && pix_write;
        mem_waddr = addr_q;
        mem_wdata = {rsp.out_red, rsp.out_green, rsp.out_blue};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      fill_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear || state_q == StFill) begin
        fill_idx_q <= fill_last ? '0 : fill_idx_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o = out_rsp_q;

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  a_sweep_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFill || state_q == StClear) |-> mem_we && mem_waddr == fill_idx_q)
    else $error("sweep cycle without memory write");

  a_rsp_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StExec))
    else $error("response raised outside execute state");
`endif

endmodule
